[rtl/scd_pkg.sv]
// Shared types, command codes and display command bytes for the SPI display command engine.
package scd_pkg;

    localparam logic [2:0] CMD_WINDOW  = 3'd0;
    localparam logic [2:0] CMD_PIXEL   = 3'd1;
    localparam logic [2:0] CMD_ROTATE  = 3'd2;
    localparam logic [2:0] CMD_SCRAREA = 3'd3;
    localparam logic [2:0] CMD_SCROLL  = 3'd4;
    localparam logic [2:0] CMD_BRIGHT  = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOTPERM = 2'd2;
    localparam logic [1:0] ST_BUSY    = 2'd3;

    localparam logic [1:0] CFG_NATIVE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_NATIVE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_CTRL_TYPE     = 2'd2;

    localparam logic [1:0] CTRL_FIRST  = 2'd0;
    localparam logic [1:0] CTRL_SECOND = 2'd1;
    localparam logic [1:0] CTRL_THIRD  = 2'd2;

    localparam logic [7:0] DCS_CASET   = 8'h2A;
    localparam logic [7:0] DCS_PASET   = 8'h2B;
    localparam logic [7:0] DCS_RAMWR   = 8'h2C;
    localparam logic [7:0] DCS_VSCRDEF = 8'h33;
    localparam logic [7:0] DCS_MADCTL  = 8'h36;
    localparam logic [7:0] DCS_VSCSAD  = 8'h37;
    localparam logic [7:0] DCS_WRDISBV = 8'h51;
    localparam logic [7:0] DCS_WRCTRLD = 8'h53;

    localparam logic [10:0] RESET_WIDTH  = 11'd240;
    localparam logic [10:0] RESET_HEIGHT = 11'd320;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [6:0] {
        KIND_REJECT  = 7'b0000001,
        KIND_WINDOW  = 7'b0000010,
        KIND_PIXEL   = 7'b0000100,
        KIND_ROTATE  = 7'b0001000,
        KIND_SCRAREA = 7'b0010000,
        KIND_SCROLL  = 7'b0100000,
        KIND_BRIGHT  = 7'b1000000
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [1:0]        status;
        logic [10:0]       width;
        logic [10:0]       height;
        logic [3:0][15:0]  args;
    } desc_t;

    function automatic logic [7:0] madctl_value(input logic [1:0] ctype, input logic [1:0] rot);
        logic [7:0] v;
        v = 8'h00;
        case (ctype)
            CTRL_SECOND: begin
                case (rot)
                    2'd0:    v = 8'h08;
                    2'd1:    v = 8'h68;
                    2'd2:    v = 8'hC8;
                    default: v = 8'hA8;
                endcase
            end
            CTRL_THIRD: begin
                case (rot)
                    2'd0:    v = 8'h48;
                    2'd1:    v = 8'h28;
                    2'd2:    v = 8'h88;
                    default: v = 8'hE8;
                endcase
            end
            default: begin
                case (rot)
                    2'd0:    v = 8'h00;
                    2'd1:    v = 8'h61;
                    2'd2:    v = 8'hC0;
                    default: v = 8'hA0;
                endcase
            end
        endcase
        return v;
    endfunction

endpackage

[rtl/scd_front.sv]
// Command front end: configuration registers, argument checks, panel state and descriptor build.
module scd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_cmd,
    input  logic [9:0]          s_col_start,
    input  logic [9:0]          s_row_start,
    input  logic [9:0]          s_col_end,
    input  logic [9:0]          s_row_end,
    input  logic [15:0]         s_pixel_color,
    input  logic [7:0]          s_rotation_code,
    input  logic [10:0]         s_scroll_top,
    input  logic [10:0]         s_scroll_height,
    input  logic [9:0]          s_scroll_offset,
    input  logic [7:0]          s_brightness,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [10:0]         cfg_data,
    output logic                q_push,
    input  logic                q_full,
    output scd_pkg::desc_t      q_desc
);

    logic [10:0] nat_w_reg, nat_w_next;
    logic [10:0] nat_h_reg, nat_h_next;
    logic [1:0]  ctype_reg, ctype_next;
    logic        rot_odd_reg, rot_odd_next;
    logic [10:0] cur_w_reg, cur_w_next;
    logic [10:0] cur_h_reg, cur_h_next;
    logic        win_reg, win_next;
    logic [20:0] pix_reg, pix_next;

    logic        accept;
    logic        cfg_we;
    logic [10:0] dx, dy;
    logic [20:0] area;
    logic [11:0] scr_sum;
    logic        win_bad;
    scd_pkg::desc_t d;

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign cfg_we    = cfg_valid && cfg_ready;

    assign dx      = {1'b0, s_col_end} - {1'b0, s_col_start} + 11'd1;
    assign dy      = {1'b0, s_row_end} - {1'b0, s_row_start} + 11'd1;
    assign area    = {10'b0, dx} * {10'b0, dy};
    assign scr_sum = {1'b0, s_scroll_top} + {1'b0, s_scroll_height};
    assign win_bad = (s_col_start > s_col_end) || (s_row_start > s_row_end) ||
                     ({1'b0, s_col_end} >= cur_w_reg) || ({1'b0, s_row_end} >= cur_h_reg);

    always_comb begin
        d          = '0;
        d.kind     = scd_pkg::KIND_REJECT;
        d.status   = scd_pkg::ST_OK;
        d.width    = cur_w_reg;
        d.height   = cur_h_reg;
        nat_w_next   = nat_w_reg;
        nat_h_next   = nat_h_reg;
        ctype_next   = ctype_reg;
        rot_odd_next = rot_odd_reg;
        cur_w_next   = cur_w_reg;
        cur_h_next   = cur_h_reg;
        win_next     = win_reg;
        pix_next     = pix_reg;

        case (s_cmd)
            scd_pkg::CMD_WINDOW: begin
                if (win_bad) begin
                    d.status = scd_pkg::ST_INVALID;
                end else begin
                    d.kind    = scd_pkg::KIND_WINDOW;
                    d.args[0] = {6'b0, s_col_start};
                    d.args[1] = {6'b0, s_col_end};
                    d.args[2] = {6'b0, s_row_start};
                    d.args[3] = {6'b0, s_row_end};
                    win_next  = 1'b1;
                    pix_next  = area;
                end
            end
            scd_pkg::CMD_PIXEL: begin
                if (!win_reg || (pix_reg == '0)) begin
                    d.status = scd_pkg::ST_NOTPERM;
                end else begin
                    d.kind    = scd_pkg::KIND_PIXEL;
                    d.args[0] = s_pixel_color;
                    pix_next  = pix_reg - 21'd1;
                    if (pix_reg == 21'd1) begin
                        win_next = 1'b0;
                    end
                end
            end
            scd_pkg::CMD_ROTATE: begin
                if (win_reg) begin
                    d.status = scd_pkg::ST_BUSY;
                end else if (s_rotation_code > 8'd3) begin
                    d.status = scd_pkg::ST_INVALID;
                end else begin
                    d.kind       = scd_pkg::KIND_ROTATE;
                    d.args[0]    = {8'b0, scd_pkg::madctl_value(ctype_reg, s_rotation_code[1:0])};
                    rot_odd_next = s_rotation_code[0];
                    cur_w_next   = s_rotation_code[0] ? nat_h_reg : nat_w_reg;
                    cur_h_next   = s_rotation_code[0] ? nat_w_reg : nat_h_reg;
                    d.width      = cur_w_next;
                    d.height     = cur_h_next;
                end
            end
            scd_pkg::CMD_SCRAREA: begin
                if (win_reg) begin
                    d.status = scd_pkg::ST_BUSY;
                end else if (scr_sum > {1'b0, cur_h_reg}) begin
                    d.status = scd_pkg::ST_INVALID;
                end else begin
                    d.kind    = scd_pkg::KIND_SCRAREA;
                    d.args[0] = {5'b0, s_scroll_top};
                    d.args[1] = {5'b0, s_scroll_height};
                    d.args[2] = {5'b0, cur_h_reg - scr_sum[10:0]};
                end
            end
            scd_pkg::CMD_SCROLL: begin
                if (win_reg) begin
                    d.status = scd_pkg::ST_BUSY;
                end else if ({1'b0, s_scroll_offset} >= cur_h_reg) begin
                    d.status = scd_pkg::ST_INVALID;
                end else begin
                    d.kind    = scd_pkg::KIND_SCROLL;
                    d.args[0] = {6'b0, s_scroll_offset};
                end
            end
            scd_pkg::CMD_BRIGHT: begin
                if (win_reg) begin
                    d.status = scd_pkg::ST_BUSY;
                end else begin
                    d.kind    = scd_pkg::KIND_BRIGHT;
                    d.args[0] = {8'b0, s_brightness};
                end
            end
            default: begin
                d.status = scd_pkg::ST_INVALID;
            end
        endcase

        if (!accept) begin
            rot_odd_next = rot_odd_reg;
            cur_w_next   = cur_w_reg;
            cur_h_next   = cur_h_reg;
            win_next     = win_reg;
            pix_next     = pix_reg;
        end

        // register writes must only arrive while idle; the block itself does not enforce this
        if (cfg_we) begin
            case (cfg_index)
                scd_pkg::CFG_NATIVE_WIDTH:  nat_w_next = cfg_data;
                scd_pkg::CFG_NATIVE_HEIGHT: nat_h_next = cfg_data;
                scd_pkg::CFG_CTRL_TYPE:     ctype_next = cfg_data[1:0];
                default: ;
            endcase
            if ((cfg_index == scd_pkg::CFG_NATIVE_WIDTH) ||
                (cfg_index == scd_pkg::CFG_NATIVE_HEIGHT)) begin
                cur_w_next = rot_odd_reg ? nat_h_next : nat_w_next;
                cur_h_next = rot_odd_reg ? nat_w_next : nat_h_next;
            end
        end
    end

    assign q_push = accept;
    assign q_desc = d;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nat_w_reg   <= scd_pkg::RESET_WIDTH;
            nat_h_reg   <= scd_pkg::RESET_HEIGHT;
            ctype_reg   <= scd_pkg::CTRL_FIRST;
            rot_odd_reg <= 1'b0;
            cur_w_reg   <= scd_pkg::RESET_WIDTH;
            cur_h_reg   <= scd_pkg::RESET_HEIGHT;
            win_reg     <= 1'b0;
            pix_reg     <= '0;
        end else begin
            nat_w_reg   <= nat_w_next;
            nat_h_reg   <= nat_h_next;
            ctype_reg   <= ctype_next;
            rot_odd_reg <= rot_odd_next;
            cur_w_reg   <= cur_w_next;
            cur_h_reg   <= cur_h_next;
            win_reg     <= win_next;
            pix_reg     <= pix_next;
        end
    end

endmodule

[rtl/scd_queue.sv]
// Small descriptor queue between the front end and the byte sequencer.
module scd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  scd_pkg::desc_t      push_desc,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output scd_pkg::desc_t      head_desc
);

    localparam int AW = scd_pkg::QUEUE_AW;

    scd_pkg::desc_t          entry_reg [scd_pkg::QUEUE_DEPTH];
    logic [AW-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [AW:0]             count_reg, count_next;
    logic                    do_push, do_pop;

    assign full       = (count_reg == (AW+1)'(scd_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/scd_back.sv]
// Byte sequencer: walks each descriptor's byte list into the registered result port.
module scd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  scd_pkg::desc_t      q_desc,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_byte_valid,
    output logic                m_is_data,
    output logic [7:0]          m_bus_byte,
    output logic                m_release_select,
    output logic                m_last,
    output logic [1:0]          m_status,
    output logic [10:0]         m_current_width_out,
    output logic [10:0]         m_current_height_out
);

    logic [3:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic        bval_reg, data_reg, rel_reg, last_reg;
    logic [7:0]  byte_reg;
    logic [1:0]  status_reg;
    logic [10:0] w_reg, h_reg;

    logic        load;
    logic        b_val, b_data, b_rel, b_last;
    logic [7:0]  b_byte;
    logic [15:0] a0, a1, a2, a3;

    assign a0 = q_desc.args[0];
    assign a1 = q_desc.args[1];
    assign a2 = q_desc.args[2];
    assign a3 = q_desc.args[3];

    always_comb begin
        b_val  = 1'b1;
        b_data = 1'b1;
        b_rel  = 1'b0;
        b_last = 1'b0;
        b_byte = 8'h00;
        case (q_desc.kind)
            scd_pkg::KIND_WINDOW: begin
                case (idx_reg)
                    4'd0:  begin b_data = 1'b0; b_byte = scd_pkg::DCS_CASET; end
                    4'd1:  b_byte = a0[15:8];
                    4'd2:  b_byte = a0[7:0];
                    4'd3:  b_byte = a1[15:8];
                    4'd4:  begin b_byte = a1[7:0]; b_rel = 1'b1; end
                    4'd5:  begin b_data = 1'b0; b_byte = scd_pkg::DCS_PASET; end
                    4'd6:  b_byte = a2[15:8];
                    4'd7:  b_byte = a2[7:0];
                    4'd8:  b_byte = a3[15:8];
                    4'd9:  begin b_byte = a3[7:0]; b_rel = 1'b1; end
                    default: begin
                        b_data = 1'b0;
                        b_byte = scd_pkg::DCS_RAMWR;
                        b_rel  = 1'b1;
                        b_last = 1'b1;
                    end
                endcase
            end
            scd_pkg::KIND_PIXEL: begin
                if (idx_reg == 4'd0) begin
                    b_byte = a0[15:8];
                end else begin
                    b_byte = a0[7:0];
                    b_rel  = 1'b1;
                    b_last = 1'b1;
                end
            end
            scd_pkg::KIND_ROTATE: begin
                if (idx_reg == 4'd0) begin
                    b_data = 1'b0;
                    b_byte = scd_pkg::DCS_MADCTL;
                end else begin
                    b_byte = a0[7:0];
                    b_rel  = 1'b1;
                    b_last = 1'b1;
                end
            end
            scd_pkg::KIND_SCRAREA: begin
                case (idx_reg)
                    4'd0:  begin b_data = 1'b0; b_byte = scd_pkg::DCS_VSCRDEF; end
                    4'd1:  b_byte = a0[15:8];
                    4'd2:  b_byte = a0[7:0];
                    4'd3:  b_byte = a1[15:8];
                    4'd4:  b_byte = a1[7:0];
                    4'd5:  b_byte = a2[15:8];
                    default: begin b_byte = a2[7:0]; b_rel = 1'b1; b_last = 1'b1; end
                endcase
            end
            scd_pkg::KIND_SCROLL: begin
                case (idx_reg)
                    4'd0:  begin b_data = 1'b0; b_byte = scd_pkg::DCS_VSCSAD; end
                    4'd1:  b_byte = a0[15:8];
                    default: begin b_byte = a0[7:0]; b_rel = 1'b1; b_last = 1'b1; end
                endcase
            end
            scd_pkg::KIND_BRIGHT: begin
                case (idx_reg)
                    4'd0:  begin b_data = 1'b0; b_byte = scd_pkg::DCS_WRCTRLD; end
                    4'd1:  begin b_byte = scd_pkg::DCS_RAMWR; b_rel = 1'b1; end
                    4'd2:  begin b_data = 1'b0; b_byte = scd_pkg::DCS_WRDISBV; end
                    default: begin b_byte = a0[7:0]; b_rel = 1'b1; b_last = 1'b1; end
                endcase
            end
            default: begin
                // rejected command: status word only
                b_val  = 1'b0;
                b_data = 1'b0;
                b_last = 1'b1;
            end
        endcase
    end

    assign load  = q_valid && (!valid_reg || m_ready);
    assign q_pop = load && b_last;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            idx_next   = b_last ? 4'd0 : idx_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bval_reg   <= b_val;
            data_reg   <= b_data;
            byte_reg   <= b_byte;
            rel_reg    <= b_rel;
            last_reg   <= b_last;
            status_reg <= q_desc.status;
            w_reg      <= q_desc.width;
            h_reg      <= q_desc.height;
        end
    end

    assign m_valid              = valid_reg;
    assign m_byte_valid         = bval_reg;
    assign m_is_data            = data_reg;
    assign m_bus_byte           = byte_reg;
    assign m_release_select     = rel_reg;
    assign m_last               = last_reg;
    assign m_status             = status_reg;
    assign m_current_width_out  = w_reg;
    assign m_current_height_out = h_reg;

endmodule

[rtl/spi_display_command_engine.sv]
// Top level of the SPI display command engine.
// Takes one display command per cycle while the four-entry command queue has room; every
// command is checked and the panel state updated as it is accepted. The byte sequencer then
// hands out one result word per cycle while the result port is ready: a pixel push gives 2
// words, rotation 2, scroll 3, brightness 4, scroll area 7, set window 11, and a rejected
// command 1 status-only word. Sustained throughput is set by that sequencer. Configuration writes
// are taken every cycle; native size writes reload the logical size at once.
module spi_display_command_engine (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [2:0]    s_cmd,
    input  logic [9:0]    s_col_start,
    input  logic [9:0]    s_row_start,
    input  logic [9:0]    s_col_end,
    input  logic [9:0]    s_row_end,
    input  logic [15:0]   s_pixel_color,
    input  logic [7:0]    s_rotation_code,
    input  logic [10:0]   s_scroll_top,
    input  logic [10:0]   s_scroll_height,
    input  logic [9:0]    s_scroll_offset,
    input  logic [7:0]    s_brightness,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_byte_valid,
    output logic          m_is_data,
    output logic [7:0]    m_bus_byte,
    output logic          m_release_select,
    output logic          m_last,
    output logic [1:0]    m_status,
    output logic [10:0]   m_current_width_out,
    output logic [10:0]   m_current_height_out,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [10:0]   cfg_data
);

    logic           q_push, q_full, q_pop, q_valid;
    scd_pkg::desc_t q_in, q_head;

    scd_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_col_start     (s_col_start),
        .s_row_start     (s_row_start),
        .s_col_end       (s_col_end),
        .s_row_end       (s_row_end),
        .s_pixel_color   (s_pixel_color),
        .s_rotation_code (s_rotation_code),
        .s_scroll_top    (s_scroll_top),
        .s_scroll_height (s_scroll_height),
        .s_scroll_offset (s_scroll_offset),
        .s_brightness    (s_brightness),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .q_push          (q_push),
        .q_full          (q_full),
        .q_desc          (q_in)
    );

    scd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_desc  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_desc  (q_head)
    );

    scd_back u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .q_valid              (q_valid),
        .q_desc               (q_head),
        .q_pop                (q_pop),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_byte_valid         (m_byte_valid),
        .m_is_data            (m_is_data),
        .m_bus_byte           (m_bus_byte),
        .m_release_select     (m_release_select),
        .m_last               (m_last),
        .m_status             (m_status),
        .m_current_width_out  (m_current_width_out),
        .m_current_height_out (m_current_height_out)
    );

endmodule

[test/tb_spi_display_command_engine.sv]
// Self-checking testbench for the SPI display command engine: directed and random commands.
module tb_spi_display_command_engine;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;
    localparam logic [1:0] CTRL_SPARE = 2'd3;
    localparam logic [7:0] BCTRL_ON = 8'h2C;
    // orientation bytes, row per controller kind, lowest byte is first kind at rotation 0
    localparam logic [95:0] ORIENT_BYTES = {
        8'hE8, 8'h88, 8'h28, 8'h48,
        8'hA8, 8'hC8, 8'h68, 8'h08,
        8'hA0, 8'hC0, 8'h61, 8'h00
    };

    typedef struct packed {
        logic [2:0]  cmd;
        logic [9:0]  col_start;
        logic [9:0]  row_start;
        logic [9:0]  col_end;
        logic [9:0]  row_end;
        logic [15:0] pixel_color;
        logic [7:0]  rotation_code;
        logic [10:0] scroll_top;
        logic [10:0] scroll_height;
        logic [9:0]  scroll_offset;
        logic [7:0]  brightness;
    } cmd_item_t;

    typedef struct packed {
        logic        byte_valid;
        logic        is_data;
        logic [7:0]  bus_byte;
        logic        release_select;
        logic        last;
        logic [1:0]  status;
        logic [10:0] width;
        logic [10:0] height;
    } bus_word_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_cmd = '0;
    logic [9:0] s_col_start = '0;
    logic [9:0] s_row_start = '0;
    logic [9:0] s_col_end = '0;
    logic [9:0] s_row_end = '0;
    logic [15:0] s_pixel_color = '0;
    logic [7:0] s_rotation_code = '0;
    logic [10:0] s_scroll_top = '0;
    logic [10:0] s_scroll_height = '0;
    logic [9:0] s_scroll_offset = '0;
    logic [7:0] s_brightness = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_byte_valid;
    logic m_is_data;
    logic [7:0] m_bus_byte;
    logic m_release_select;
    logic m_last;
    logic [1:0] m_status;
    logic [10:0] m_current_width_out;
    logic [10:0] m_current_height_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [10:0] cfg_data = '0;

    spi_display_command_engine u_top (.*);

    // predictor state
    logic [10:0] panel_w_native = scd_pkg::RESET_WIDTH;
    logic [10:0] panel_h_native = scd_pkg::RESET_HEIGHT;
    logic [1:0] panel_kind = scd_pkg::CTRL_FIRST;
    logic [1:0] view_rot = 2'd0;
    logic [10:0] view_w = scd_pkg::RESET_WIDTH;
    logic [10:0] view_h = scd_pkg::RESET_HEIGHT;
    logic window_live = 1'b0;
    logic [20:0] pixels_owed = '0;

    bus_word_t pending_spi_words[$];
    bus_word_t cmd_bytes[$];

    int src_idle_pct = 17;
    int sink_idle_pct = 61;
    int items_sent = 0;
    int words_seen = 0;
    int error_count = 0;
    int cycle_count = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[spi_display_command_engine] ERROR");
        $finish;
    end

    always @(posedge aclk) m_ready <= ($urandom_range(99) >= sink_idle_pct);

    task automatic flag_mismatch(input string msg);
        error_count++;
        if (error_count <= 200) $display("mismatch at word %0d: %s", words_seen, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    always @(posedge aclk) begin : word_check
        bus_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_spi_words.size() == 0) begin
                flag_mismatch("result word with nothing expected");
            end else begin
                want = pending_spi_words.pop_front();
                check_field("byte_valid", 16'(m_byte_valid), 16'(want.byte_valid));
                check_field("is_data", 16'(m_is_data), 16'(want.is_data));
                check_field("bus_byte", 16'(m_bus_byte), 16'(want.bus_byte));
                check_field("release_select", 16'(m_release_select),
                            16'(want.release_select));
                check_field("last", 16'(m_last), 16'(want.last));
                check_field("status", 16'(m_status), 16'(want.status));
                check_field("width", 16'(m_current_width_out), 16'(want.width));
                check_field("height", 16'(m_current_height_out), 16'(want.height));
            end
            words_seen++;
        end
    end

    function automatic void reload_view();
        if (view_rot[0]) begin
            view_w = panel_h_native;
            view_h = panel_w_native;
        end else begin
            view_w = panel_w_native;
            view_h = panel_h_native;
        end
    endfunction

    function automatic void put_byte(input logic data_flag, input logic [7:0] value,
                                     input logic rel);
        bus_word_t w;
        w = '0;
        w.byte_valid = 1'b1;
        w.is_data = data_flag;
        w.bus_byte = value;
        w.release_select = rel;
        cmd_bytes.push_back(w);
    endfunction

    function automatic void put_pair(input logic [15:0] value, input logic rel_lo);
        put_byte(1'b1, value[15:8], 1'b0);
        put_byte(1'b1, value[7:0], rel_lo);
    endfunction

    function automatic void predict_spi_bytes(input cmd_item_t it);
        logic [1:0] st;
        int span_x;
        int span_y;
        int row;
        bus_word_t w;
        st = scd_pkg::ST_OK;
        cmd_bytes.delete();
        case (it.cmd)
            scd_pkg::CMD_WINDOW: begin
                if (it.col_start > it.col_end || it.row_start > it.row_end ||
                    it.col_end >= view_w || it.row_end >= view_h) begin
                    st = scd_pkg::ST_INVALID;
                end else begin
                    span_x = int'(it.col_end) - int'(it.col_start) + 1;
                    span_y = int'(it.row_end) - int'(it.row_start) + 1;
                    window_live = 1'b1;
                    pixels_owed = 21'(span_x * span_y);
                    put_byte(1'b0, scd_pkg::DCS_CASET, 1'b0);
                    put_pair(16'(it.col_start), 1'b0);
                    put_pair(16'(it.col_end), 1'b1);
                    put_byte(1'b0, scd_pkg::DCS_PASET, 1'b0);
                    put_pair(16'(it.row_start), 1'b0);
                    put_pair(16'(it.row_end), 1'b1);
                    put_byte(1'b0, scd_pkg::DCS_RAMWR, 1'b1);
                end
            end
            scd_pkg::CMD_PIXEL: begin
                if (!window_live || pixels_owed == 0) begin
                    st = scd_pkg::ST_NOTPERM;
                end else begin
                    put_pair(it.pixel_color, 1'b1);
                    pixels_owed--;
                    if (pixels_owed == 0) window_live = 1'b0;
                end
            end
            scd_pkg::CMD_ROTATE: begin
                if (window_live) begin
                    st = scd_pkg::ST_BUSY;
                end else if (it.rotation_code > 8'd3) begin
                    st = scd_pkg::ST_INVALID;
                end else begin
                    row = (panel_kind == CTRL_SPARE) ? 0 : int'(panel_kind);
                    put_byte(1'b0, scd_pkg::DCS_MADCTL, 1'b0);
                    put_byte(1'b1, ORIENT_BYTES[(row * 4 + int'(it.rotation_code)) * 8 +: 8],
                             1'b1);
                    view_rot = it.rotation_code[1:0];
                    reload_view();
                end
            end
            scd_pkg::CMD_SCRAREA: begin
                if (window_live) begin
                    st = scd_pkg::ST_BUSY;
                end else if (int'(it.scroll_top) + int'(it.scroll_height) > int'(view_h)) begin
                    st = scd_pkg::ST_INVALID;
                end else begin
                    put_byte(1'b0, scd_pkg::DCS_VSCRDEF, 1'b0);
                    put_pair(16'(it.scroll_top), 1'b0);
                    put_pair(16'(it.scroll_height), 1'b0);
                    put_pair(16'(view_h - it.scroll_top - it.scroll_height), 1'b1);
                end
            end
            scd_pkg::CMD_SCROLL: begin
                if (window_live) begin
                    st = scd_pkg::ST_BUSY;
                end else if (it.scroll_offset >= view_h) begin
                    st = scd_pkg::ST_INVALID;
                end else begin
                    put_byte(1'b0, scd_pkg::DCS_VSCSAD, 1'b0);
                    put_pair(16'(it.scroll_offset), 1'b1);
                end
            end
            scd_pkg::CMD_BRIGHT: begin
                if (window_live) begin
                    st = scd_pkg::ST_BUSY;
                end else begin
                    put_byte(1'b0, scd_pkg::DCS_WRCTRLD, 1'b0);
                    put_byte(1'b1, BCTRL_ON, 1'b1);
                    put_byte(1'b0, scd_pkg::DCS_WRDISBV, 1'b0);
                    put_byte(1'b1, it.brightness, 1'b1);
                end
            end
            default: st = scd_pkg::ST_INVALID;
        endcase
        if (cmd_bytes.size() == 0) cmd_bytes.push_back('0);
        foreach (cmd_bytes[i]) begin
            w = cmd_bytes[i];
            w.last = (i == cmd_bytes.size() - 1);
            w.status = st;
            w.width = view_w;
            w.height = view_h;
            pending_spi_words.push_back(w);
        end
    endfunction

    task automatic send_cmd(input cmd_item_t it);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_cmd <= it.cmd;
        s_col_start <= it.col_start;
        s_row_start <= it.row_start;
        s_col_end <= it.col_end;
        s_row_end <= it.row_end;
        s_pixel_color <= it.pixel_color;
        s_rotation_code <= it.rotation_code;
        s_scroll_top <= it.scroll_top;
        s_scroll_height <= it.scroll_height;
        s_scroll_offset <= it.scroll_offset;
        s_brightness <= it.brightness;
        do @(posedge aclk); while (!s_ready);
        predict_spi_bytes(it);
        items_sent++;
    endtask

    task automatic wait_drain();
        if (s_valid) s_valid <= 1'b0;
        while (pending_spi_words.size() != 0) @(posedge aclk);
    endtask

    task automatic set_panel(input logic [10:0] w, input logic [10:0] h,
                             input logic [1:0] kind);
        logic [10:0] reg_vals [0:2];
        logic [1:0] reg_sel;
        wait_drain();
        reg_vals[scd_pkg::CFG_NATIVE_WIDTH] = w;
        reg_vals[scd_pkg::CFG_NATIVE_HEIGHT] = h;
        reg_vals[scd_pkg::CFG_CTRL_TYPE] = {9'd0, kind};
        for (int i = 0; i < 3; i++) begin
            reg_sel = 2'(i);
            cfg_valid <= 1'b1;
            cfg_index <= reg_sel;
            cfg_data <= reg_vals[i];
            do @(posedge aclk); while (!cfg_ready);
            case (reg_sel)
                scd_pkg::CFG_NATIVE_WIDTH: begin
                    panel_w_native = reg_vals[i];
                    reload_view();
                end
                scd_pkg::CFG_NATIVE_HEIGHT: begin
                    panel_h_native = reg_vals[i];
                    reload_view();
                end
                scd_pkg::CFG_CTRL_TYPE: panel_kind = reg_vals[i][1:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic cmd_item_t any_item();
        cmd_item_t it;
        it.cmd = 3'($urandom_range(7));
        it.col_start = 10'($urandom);
        it.row_start = 10'($urandom);
        it.col_end = 10'($urandom);
        it.row_end = 10'($urandom);
        it.pixel_color = 16'($urandom);
        it.rotation_code = 8'($urandom);
        it.scroll_top = 11'($urandom);
        it.scroll_height = 11'($urandom);
        it.scroll_offset = 10'($urandom);
        it.brightness = 8'($urandom);
        return it;
    endfunction

    task automatic send_op(input logic [2:0] op);
        cmd_item_t it;
        it = any_item();
        it.cmd = op;
        send_cmd(it);
    endtask

    task automatic send_window(input logic [9:0] x0, input logic [9:0] y0,
                               input logic [9:0] x1, input logic [9:0] y1);
        cmd_item_t it;
        it = any_item();
        it.cmd = scd_pkg::CMD_WINDOW;
        it.col_start = x0;
        it.row_start = y0;
        it.col_end = x1;
        it.row_end = y1;
        send_cmd(it);
    endtask

    task automatic send_pixel(input logic [15:0] colour);
        cmd_item_t it;
        it = any_item();
        it.cmd = scd_pkg::CMD_PIXEL;
        it.pixel_color = colour;
        send_cmd(it);
    endtask

    task automatic send_rotation(input logic [7:0] code);
        cmd_item_t it;
        it = any_item();
        it.cmd = scd_pkg::CMD_ROTATE;
        it.rotation_code = code;
        send_cmd(it);
    endtask

    task automatic send_scroll_area(input logic [10:0] top, input logic [10:0] hgt);
        cmd_item_t it;
        it = any_item();
        it.cmd = scd_pkg::CMD_SCRAREA;
        it.scroll_top = top;
        it.scroll_height = hgt;
        send_cmd(it);
    endtask

    task automatic send_scroll(input logic [9:0] off);
        cmd_item_t it;
        it = any_item();
        it.cmd = scd_pkg::CMD_SCROLL;
        it.scroll_offset = off;
        send_cmd(it);
    endtask

    task automatic send_brightness(input logic [7:0] level);
        cmd_item_t it;
        it = any_item();
        it.cmd = scd_pkg::CMD_BRIGHT;
        it.brightness = level;
        send_cmd(it);
    endtask

    // small legal window, then its pixels; sometimes cut short or interrupted
    task automatic window_burst();
        int wd;
        int ht;
        int x0;
        int y0;
        int cut;
        if (view_w == 0 || view_h == 0) begin
            send_cmd(any_item());
            return;
        end
        wd = $urandom_range(view_w < 4 ? view_w : 4, 1);
        ht = $urandom_range(view_h < 3 ? view_h : 3, 1);
        x0 = $urandom_range(view_w - wd, 0);
        y0 = $urandom_range(view_h - ht, 0);
        send_window(10'(x0), 10'(y0), 10'(x0 + wd - 1), 10'(y0 + ht - 1));
        cut = ($urandom_range(7) == 0) ? $urandom_range(wd * ht - 1, 0) : wd * ht;
        for (int i = 0; i < cut; i++) begin
            if ($urandom_range(9) == 0) begin
                send_op(3'($urandom_range(scd_pkg::CMD_BRIGHT, scd_pkg::CMD_ROTATE)));
            end
            send_pixel(16'($urandom));
        end
    endtask

    task automatic legal_command();
        int top;
        case ($urandom_range(3))
            0: send_rotation(8'($urandom_range(3)));
            1: begin
                top = $urandom_range(view_h, 0);
                send_scroll_area(11'(top), 11'($urandom_range(view_h - top, 0)));
            end
            2: send_scroll(view_h == 0 ? 10'd0 : 10'($urandom_range(view_h - 1, 0)));
            default: send_brightness(8'($urandom));
        endcase
    endtask

    function automatic logic [10:0] random_size();
        case ($urandom_range(3))
            0: return 11'd1024;
            1: return 11'($urandom_range(16, 1));
            default: return 11'($urandom_range(1024, 1));
        endcase
    endfunction

    task automatic test_window_and_pixels();
        send_window(10'd0, 10'd0, 10'd1, 10'd0);
        send_rotation(8'd1);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_pixel(16'h1234);
        send_window(10'd5, 10'd0, 10'd4, 10'd0);
        send_window(10'd0, 10'd0, 10'd240, 10'd0);
        send_window(10'd239, 10'd319, 10'd239, 10'd319);
        send_window(10'd0, 10'd0, 10'd0, 10'd0);
        send_pixel(16'hA5A5);
    endtask

    task automatic test_commands();
        send_rotation(8'd4);
        send_rotation(8'd255);
        send_rotation(8'd1);
        send_scroll_area(11'd100, 11'd141);
        send_scroll_area(11'd0, 11'd240);
        send_scroll(10'd240);
        send_scroll(10'd239);
        send_brightness(8'd255);
        send_brightness(8'd0);
        send_op(CMD_SPARE_A);
        send_op(CMD_SPARE_B);
    endtask

    task automatic test_controller_kinds();
        set_panel(11'd240, 11'd320, scd_pkg::CTRL_SECOND);
        send_rotation(8'd3);
        set_panel(11'd240, 11'd320, scd_pkg::CTRL_THIRD);
        send_rotation(8'd2);
        set_panel(11'd240, 11'd320, CTRL_SPARE);
        send_rotation(8'd1);
    endtask

    task automatic test_panel_extremes();
        set_panel(11'd1024, 11'd1024, scd_pkg::CTRL_FIRST);
        send_window(10'd0, 10'd0, 10'd1023, 10'd1023);
        send_scroll(10'd5);
        send_window(10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send_pixel(16'h8001);
        // zero native width: every window fails the bounds test
        set_panel(11'd0, 11'd1, scd_pkg::CTRL_FIRST);
        send_window(10'd0, 10'd0, 10'd0, 10'd0);
        send_scroll(10'd0);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items);
        int stop_at;
        int pick;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        set_panel(random_size(), random_size(), 2'($urandom_range(3)));
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 3) wait_drain();
            else if (pick < 55) window_burst();
            else if (pick < 85) legal_command();
            else send_cmd(any_item());
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_window_and_pixels();
        test_commands();
        test_controller_kinds();
        test_panel_extremes();
        test_random_traffic(17, 61, 43);
        test_random_traffic(61, 17, 43);
        test_random_traffic(0, 0, 43);
        wait_drain();
        repeat (16) @(posedge aclk);
        if (error_count == 0) begin
            $display("[spi_display_command_engine] OK");
        end else begin
            $display("[spi_display_command_engine] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/scd_pkg.sv
rtl/scd_front.sv
rtl/scd_queue.sv
rtl/scd_back.sv
rtl/spi_display_command_engine.sv
test/tb_spi_display_command_engine.sv
